FILE: hdl/gcm_pkg.sv
// Package for the grid coverage map: cell state codes, opcodes and field widths.
// Used by grid_coverage_map; depends on nothing.
package gcm_pkg;
   localparam int unsigned CoordW = 24;
   localparam int unsigned EdgeW = 16;
   localparam int unsigned CntW = 5;

   typedef enum logic [1:0] {
      ST_DIRTY = 2'd0,
      ST_CLEAN = 2'd1,
      ST_OBSTACLE = 2'd2,
      ST_NONE = 2'd3
   } cell_state_type;

   typedef enum logic [2:0] {
      OP_SET_ROBOT = 3'd0,
      OP_MARK = 3'd1,
      OP_RECOLOR = 3'd2,
      OP_NEAREST = 3'd3,
      OP_LOCATE = 3'd4,
      OP_ZIGZAG = 3'd5,
      OP_CENTER = 3'd6,
      OP_NOP = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_CELL_EDGE = 3'd2,
      REG_COLS_USED = 3'd3,
      REG_ROWS_USED = 3'd4
   } reg_index_type;

   function automatic logic signed [CoordW-1:0] sat24(input logic signed [47:0] v);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      begin
         hi = 48'sd8388607;
         lo = -48'sd8388608;
         if (v > hi) begin
            sat24 = 24'sh7FFFFF;
         end else if (v < lo) begin
            sat24 = 24'sh800000;
         end else begin
            sat24 = v[CoordW-1:0];
         end
      end
   endfunction
endpackage

FILE: hdl/grid_coverage_map.sv
// Grid coverage map: cell states in one synchronous memory, scanned one cell per cycle.
// Depends on gcm_pkg.
//
// Usage. Words enter on req_ (valid/stall) and one result word leaves on rsp_
// for each of them. Configuration writes go over csr_ (valid/ready, index and data);
// csr_ready is high only while the block is idle and no request word is offered.
// After reset the block first sweeps the cell memory, writing every entry dirty,
// one entry per cycle; req_stall stays
// high during that sweep.
// A recolor, nearest or locate word first scans the used grid (one memory read
// per cycle, with write-back for recolor) and drains the distance pipeline, then
// runs a second scan for the clean flags, drains again and computes the centers.
// Other words skip the first scan. The block takes no new word until the result
// has left and it is back in idle; the single read port of the memory makes each
// scan go one cell at a time.
// Distances use a two-stage squared path so at most one multiply sits between
// registers. The result is held in an output register; while rsp_stall is
// high it stays and no new word is taken.
module grid_coverage_map #(
   parameter int unsigned MAX_COLS = 16,
   parameter int unsigned MAX_ROWS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_opcode,
   input  logic [3:0]                  req_cell_x,
   input  logic [3:0]                  req_cell_y,
   input  logic [1:0]                  req_state_a,
   input  logic [1:0]                  req_state_b,
   input  logic signed [23:0]          req_point_x,
   input  logic signed [23:0]          req_point_y,
   input  logic [23:0]                 req_threshold,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [3:0]                  rsp_result_x,
   output logic [3:0]                  rsp_result_y,
   output logic signed [23:0]          rsp_center_x,
   output logic signed [23:0]          rsp_center_y,
   output logic                        rsp_no_dirty_left,
   output logic                        rsp_all_clean,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [23:0]                 csr_data
);
   import gcm_pkg::*;

   localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned AddrW = ColW + RowW;
   localparam int unsigned Depth = 1 << AddrW;
   localparam int unsigned IdxW = 7;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_FLAGS, S_FDRAIN, S_FIN, S_OUT
   } fsm_type;

   logic [1:0] mem [Depth];
   logic [1:0] rd_data_ff;

   fsm_type state_ff;
   logic [AddrW:0] clr_ff;
   logic signed [23:0] org_x_ff, org_y_ff;
   logic [15:0] edge_ff;
   logic [4:0] cols_ff, rows_ff;
   logic [3:0] robot_col_ff, robot_row_ff;

   logic [2:0] op_ff;
   logic [1:0] sa_ff, sb_ff;
   logic signed [23:0] px_ff, py_ff;
   logic [47:0] lim_ff;

   logic [ColW-1:0] ci_ff;
   logic [RowW-1:0] rj_ff;
   // pipeline: p1 = memory read of cell, p2 = differences, p3 = squares and compare
   logic p1_v_ff, p2_v_ff, p3_v_ff;
   logic [ColW-1:0] p1_i_ff, p2_i_ff, p3_i_ff;
   logic [RowW-1:0] p1_j_ff, p2_j_ff, p3_j_ff;
   logic p2_m_ff, p3_m_ff;
   logic signed [25:0] dx_ff, dy_ff;
   logic [50:0] sq_ff;

   logic found_ff, show_ff;
   logic [IdxW-1:0] rx_ff, ry_ff;
   logic [50:0] best_ff;
   logic nodirty_ff, allclean_ff;
   logic signed [47:0] ctrx_ff, ctry_ff;

   logic [4:0] nc, nr;
   logic [ColW-1:0] last_i;
   logic [RowW-1:0] last_j;
   logic [AddrW-1:0] rd_addr;
   logic wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [1:0] wr_data;
   logic signed [47:0] ctr_x, ctr_y;
   logic signed [51:0] dx_sq, dy_sq;
   logic [50:0] dsq;

   always_comb begin
      nc = (cols_ff == 5'd0) ? 5'd1 : cols_ff;
      nr = (rows_ff == 5'd0) ? 5'd1 : rows_ff;
      if (32'(nc) > MAX_COLS) nc = 5'(MAX_COLS);
      if (32'(nr) > MAX_ROWS) nr = 5'(MAX_ROWS);
      last_i = ColW'(nc - 5'd1);
      last_j = RowW'(nr - 5'd1);
      rd_addr = {ci_ff, rj_ff};
      ctr_x = 48'(org_x_ff) + $signed({32'd0, edge_ff}) * $signed({41'd0, p1_i_ff});
      ctr_y = 48'(org_y_ff) + $signed({32'd0, edge_ff}) * $signed({41'd0, p1_j_ff});
      dx_sq = dx_ff * dx_ff;
      dy_sq = dy_ff * dy_ff;
      dsq = sq_ff;
      wr_en = 1'b0;
      wr_addr = {p1_i_ff, p1_j_ff};
      wr_data = sb_ff;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff[AddrW-1:0];
         wr_data = ST_DIRTY;
      end else if (state_ff == S_IDLE && req_valid && !req_stall
                   && req_opcode == OP_MARK && 5'(req_cell_x) < nc
                   && 5'(req_cell_y) < nr && req_state_a != ST_NONE
                   && 32'(req_cell_x) < MAX_COLS && 32'(req_cell_y) < MAX_ROWS) begin
         wr_en = 1'b1;
         wr_addr = {ColW'(req_cell_x), RowW'(req_cell_y)};
         wr_data = req_state_a;
      end else if ((state_ff == S_SCAN || state_ff == S_DRAIN) && p1_v_ff
                   && op_ff == OP_RECOLOR && sb_ff != ST_NONE && rd_data_ff == sa_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_found = found_ff;
   assign rsp_result_x = show_ff ? rx_ff[3:0] : 4'd0;
   assign rsp_result_y = show_ff ? ry_ff[3:0] : 4'd0;
   assign rsp_center_x = show_ff ? sat24(ctrx_ff) : 24'sd0;
   assign rsp_center_y = show_ff ? sat24(ctry_ff) : 24'sd0;
   assign rsp_no_dirty_left = nodirty_ff;
   assign rsp_all_clean = allclean_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         org_x_ff <= '0;
         org_y_ff <= '0;
         edge_ff <= 16'd500;
         cols_ff <= 5'd8;
         rows_ff <= 5'd8;
         robot_col_ff <= '0;
         robot_row_ff <= '0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
      end else begin
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p2_i_ff <= p1_i_ff;
         p2_j_ff <= p1_j_ff;
         p3_i_ff <= p2_i_ff;
         p3_j_ff <= p2_j_ff;
         p2_m_ff <= (rd_data_ff == sa_ff);
         p3_m_ff <= p2_m_ff;
         dx_ff <= 26'(ctr_x - 48'(px_ff));
         dy_ff <= 26'(ctr_y - 48'(py_ff));
         sq_ff <= 51'(dx_sq) + 51'(dy_sq);
         p1_i_ff <= ci_ff;
         p1_j_ff <= rj_ff;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == Depth - 1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (csr_valid && csr_ready) begin
                  case (csr_index)
                     REG_ORIGIN_X: org_x_ff <= csr_data;
                     REG_ORIGIN_Y: org_y_ff <= csr_data;
                     REG_CELL_EDGE: edge_ff <= csr_data[15:0];
                     REG_COLS_USED: cols_ff <= csr_data[4:0];
                     REG_ROWS_USED: rows_ff <= csr_data[4:0];
                     default: ;
                  endcase
               end
               if (req_valid) begin
                  op_ff <= req_opcode;
                  sa_ff <= req_state_a;
                  sb_ff <= req_state_b;
                  px_ff <= req_point_x;
                  py_ff <= req_point_y;
                  lim_ff <= 48'(req_threshold) * 48'(req_threshold);
                  best_ff <= '0;
                  nodirty_ff <= 1'b1;
                  allclean_ff <= 1'b1;
                  ci_ff <= '0;
                  rj_ff <= '0;
                  case (opcode_type'(req_opcode))
                     OP_SET_ROBOT: begin
                        robot_col_ff <= req_cell_x;
                        robot_row_ff <= req_cell_y;
                        found_ff <= 1'b1;
                        show_ff <= 1'b1;
                        rx_ff <= IdxW'(req_cell_x);
                        ry_ff <= IdxW'(req_cell_y);
                        state_ff <= S_FLAGS;
                     end
                     OP_MARK: begin
                        found_ff <= wr_en;
                        show_ff <= 1'b1;
                        rx_ff <= IdxW'(req_cell_x);
                        ry_ff <= IdxW'(req_cell_y);
                        state_ff <= S_FLAGS;
                     end
                     OP_RECOLOR, OP_NEAREST, OP_LOCATE: begin
                        found_ff <= 1'b0;
                        show_ff <= 1'b0;
                        rx_ff <= '0;
                        ry_ff <= '0;
                        state_ff <= S_SCAN;
                     end
                     OP_ZIGZAG: begin
                        found_ff <= 1'b1;
                        show_ff <= 1'b1;
                        if (5'(robot_col_ff) < nc - 5'd1) begin
                           rx_ff <= IdxW'(robot_col_ff) + 1'b1;
                           ry_ff <= IdxW'(robot_row_ff);
                        end else if (5'(robot_row_ff) < nr - 5'd1) begin
                           rx_ff <= '0;
                           ry_ff <= IdxW'(robot_row_ff) + 1'b1;
                        end else begin
                           rx_ff <= '0;
                           ry_ff <= '0;
                        end
                        state_ff <= S_FLAGS;
                     end
                     OP_CENTER: begin
                        found_ff <= 1'b1;
                        show_ff <= 1'b1;
                        rx_ff <= IdxW'(req_cell_x);
                        ry_ff <= IdxW'(req_cell_y);
                        state_ff <= S_FLAGS;
                     end
                     default: begin
                        found_ff <= 1'b0;
                        show_ff <= 1'b0;
                        rx_ff <= '0;
                        ry_ff <= '0;
                        state_ff <= S_FLAGS;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               // read address advances column-major; p1_v marks a cell whose data arrives now
               p1_v_ff <= 1'b1;
               if (rj_ff == last_j) begin
                  rj_ff <= '0;
                  if (ci_ff == last_i) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     ci_ff <= ci_ff + 1'b1;
                  end
               end else begin
                  rj_ff <= rj_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               p1_v_ff <= 1'b0;
               if (!p1_v_ff && !p2_v_ff && !p3_v_ff) begin
                  ci_ff <= '0;
                  rj_ff <= '0;
                  state_ff <= S_FLAGS;
               end
            end
            S_FLAGS: begin
               p1_v_ff <= 1'b1;
               if (rj_ff == last_j) begin
                  rj_ff <= '0;
                  if (ci_ff == last_i) begin
                     state_ff <= S_FDRAIN;
                  end else begin
                     ci_ff <= ci_ff + 1'b1;
                  end
               end else begin
                  rj_ff <= rj_ff + 1'b1;
               end
            end
            S_FDRAIN: begin
               p1_v_ff <= 1'b0;
               if (!p1_v_ff) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               ctrx_ff <= 48'(org_x_ff) + $signed({32'd0, edge_ff}) * $signed({41'd0, rx_ff});
               ctry_ff <= 48'(org_y_ff) + $signed({32'd0, edge_ff}) * $signed({41'd0, ry_ff});
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // flag scan collects from the memory read stage
         if ((state_ff == S_FLAGS || state_ff == S_FDRAIN) && p1_v_ff) begin
            if (rd_data_ff == ST_DIRTY) nodirty_ff <= 1'b0;
            if (rd_data_ff != ST_CLEAN) allclean_ff <= 1'b0;
         end
         // search results collect at the square stage
         if ((state_ff == S_SCAN || state_ff == S_DRAIN) && p3_v_ff) begin
            if (op_ff == OP_NEAREST && p3_m_ff && (!found_ff || dsq < best_ff)) begin
               found_ff <= 1'b1;
               show_ff <= 1'b1;
               best_ff <= dsq;
               rx_ff <= IdxW'(p3_i_ff);
               ry_ff <= IdxW'(p3_j_ff);
            end
            if (op_ff == OP_LOCATE && !found_ff && dsq < 51'(lim_ff)) begin
               found_ff <= 1'b1;
               show_ff <= 1'b1;
               rx_ff <= IdxW'(p3_i_ff);
               ry_ff <= IdxW'(p3_j_ff);
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accept while busy");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_clean |-> rsp_no_dirty_left) else $error("flag mismatch");
`endif
endmodule

FILE: tb/sv/tb_grid_coverage_map.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_coverage_map: directed, configuration and random tests,
// with an in-order predictor of the cell grid and robot cell. Depends on gcm_pkg.
module tb_grid_coverage_map;
   import gcm_pkg::*;

   localparam int GRID = 16;
   localparam longint CYCLE_LIMIT = 6000000;
   localparam int DRAIN_CYCLES = 600;

   typedef struct {
      opcode_type op;
      logic [3:0] cx;
      logic [3:0] cy;
      logic [1:0] sa;
      logic [1:0] sb;
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic [23:0] thr;
   } map_word_type;

   typedef struct {
      logic found;
      logic [3:0] rx;
      logic [3:0] ry;
      logic signed [23:0] ctx;
      logic signed [23:0] cty;
      logic no_dirty;
      logic all_clean;
   } map_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic [3:0] req_cell_x = '0;
   logic [3:0] req_cell_y = '0;
   logic [1:0] req_state_a = '0;
   logic [1:0] req_state_b = '0;
   logic signed [23:0] req_point_x = '0;
   logic signed [23:0] req_point_y = '0;
   logic [23:0] req_threshold = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic [3:0] rsp_result_x;
   logic [3:0] rsp_result_y;
   logic signed [23:0] rsp_center_x;
   logic signed [23:0] rsp_center_y;
   logic rsp_no_dirty_left;
   logic rsp_all_clean;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   longint cycles = 0;
   int errors = 0;
   bit idling_on = 1'b1;
   map_answer_type pending_answers[$];

   cell_state_type grid_state[GRID][GRID];
   logic [3:0] robot_col;
   logic [3:0] robot_row;
   longint org_x;
   longint org_y;
   longint edge_mm;
   int cols_reg;
   int rows_reg;

   grid_coverage_map DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("grid_coverage_map verification failed");
         $finish;
      end
   end

   function automatic int used_cols();
      return (cols_reg < 1) ? 1 : ((cols_reg > GRID) ? GRID : cols_reg);
   endfunction

   function automatic int used_rows();
      return (rows_reg < 1) ? 1 : ((rows_reg > GRID) ? GRID : rows_reg);
   endfunction

   function automatic logic signed [23:0] clamp24(longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   function automatic longint dist_sq(int i, int j, longint px, longint py);
      longint dx;
      longint dy;
      dx = org_x + i * edge_mm - px;
      dy = org_y + j * edge_mm - py;
      return dx * dx + dy * dy;
   endfunction

   function automatic map_answer_type apply_word(map_word_type w);
      map_answer_type a;
      int nc;
      int nr;
      int rx;
      int ry;
      bit show;
      longint best;
      longint d;
      longint lim;
      nc = used_cols();
      nr = used_rows();
      a = '{default: '0};
      show = 1'b0;
      rx = 0;
      ry = 0;
      best = 0;
      case (w.op)
         OP_SET_ROBOT: begin
            robot_col = w.cx;
            robot_row = w.cy;
            a.found = 1'b1; show = 1'b1; rx = int'(w.cx); ry = int'(w.cy);
         end
         OP_MARK: begin
            if (w.cx < nc && w.cy < nr && w.sa != ST_NONE) begin
               grid_state[w.cx][w.cy] = cell_state_type'(w.sa);
               a.found = 1'b1;
            end
            show = 1'b1; rx = int'(w.cx); ry = int'(w.cy);
         end
         OP_RECOLOR: begin
            if (w.sb != ST_NONE) begin
               for (int i = 0; i < nc; i++) begin
                  for (int j = 0; j < nr; j++) begin
                     if (grid_state[i][j] == w.sa) grid_state[i][j] = cell_state_type'(w.sb);
                  end
               end
            end
         end
         OP_NEAREST: begin
            for (int i = 0; i < nc; i++) begin
               for (int j = 0; j < nr; j++) begin
                  if (grid_state[i][j] == w.sa) begin
                     d = dist_sq(i, j, w.px, w.py);
                     if (!a.found || d < best) begin
                        best = d; a.found = 1'b1; rx = i; ry = j;
                     end
                  end
               end
            end
            show = a.found;
         end
         OP_LOCATE: begin
            lim = longint'(w.thr) * longint'(w.thr);
            for (int i = 0; i < nc && !a.found; i++) begin
               for (int j = 0; j < nr && !a.found; j++) begin
                  if (dist_sq(i, j, w.px, w.py) < lim) begin
                     a.found = 1'b1; rx = i; ry = j;
                  end
               end
            end
            show = a.found;
         end
         OP_ZIGZAG: begin
            if (robot_col < nc - 1) begin
               rx = int'(robot_col) + 1; ry = int'(robot_row);
            end else if (robot_row < nr - 1) begin
               rx = 0; ry = int'(robot_row) + 1;
            end
            a.found = 1'b1; show = 1'b1;
         end
         OP_CENTER: begin
            a.found = 1'b1; show = 1'b1; rx = int'(w.cx); ry = int'(w.cy);
         end
         default: begin
         end
      endcase
      if (show) begin
         a.rx = rx[3:0];
         a.ry = ry[3:0];
         a.ctx = clamp24(org_x + rx * edge_mm);
         a.cty = clamp24(org_y + ry * edge_mm);
      end
      a.no_dirty = 1'b1;
      a.all_clean = 1'b1;
      for (int i = 0; i < nc; i++) begin
         for (int j = 0; j < nr; j++) begin
            if (grid_state[i][j] == ST_DIRTY) a.no_dirty = 1'b0;
            if (grid_state[i][j] != ST_CLEAN) a.all_clean = 1'b0;
         end
      end
      return a;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      map_answer_type e;
      if (!reset) rsp_stall <= idling_on && ($urandom_range(99) < 23);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report("unexpected word", 1, 0);
         end else begin
            e = pending_answers.pop_front();
            if (rsp_found !== e.found) report("found", rsp_found, e.found);
            if (rsp_result_x !== e.rx) report("result_x", rsp_result_x, e.rx);
            if (rsp_result_y !== e.ry) report("result_y", rsp_result_y, e.ry);
            if (rsp_center_x !== e.ctx) report("center_x", rsp_center_x, e.ctx);
            if (rsp_center_y !== e.cty) report("center_y", rsp_center_y, e.cty);
            if (rsp_no_dirty_left !== e.no_dirty)
               report("no_dirty_left", rsp_no_dirty_left, e.no_dirty);
            if (rsp_all_clean !== e.all_clean) report("all_clean", rsp_all_clean, e.all_clean);
         end
      end
   end

   task automatic send_word(map_word_type w);
      if (idling_on && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= w.op;
      req_cell_x <= w.cx;
      req_cell_y <= w.cy;
      req_state_a <= w.sa;
      req_state_b <= w.sb;
      req_point_x <= w.px;
      req_point_y <= w.py;
      req_threshold <= w.thr;
      do @(posedge clock); while (req_stall);
      pending_answers.push_back(apply_word(w));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ORIGIN_X: org_x = longint'($signed(value));
         REG_ORIGIN_Y: org_y = longint'($signed(value));
         REG_CELL_EDGE: edge_mm = longint'(value[15:0]);
         REG_COLS_USED: cols_reg = int'(value[4:0]);
         REG_ROWS_USED: rows_reg = int'(value[4:0]);
         default: begin
         end
      endcase
   endtask

   task automatic set_grid(longint ox, longint oy, int edge_len, int cols, int rows);
      write_reg(REG_ORIGIN_X, ox[23:0]);
      write_reg(REG_ORIGIN_Y, oy[23:0]);
      write_reg(REG_CELL_EDGE, 24'(edge_len));
      write_reg(REG_COLS_USED, 24'(cols));
      write_reg(REG_ROWS_USED, 24'(rows));
      csr_valid <= 1'b0;
   endtask

   function automatic map_word_type mk(opcode_type op, int cx, int cy, int sa, int sb,
                                       longint px, longint py, longint thr);
      map_word_type w;
      w.op = op; w.cx = 4'(cx); w.cy = 4'(cy); w.sa = 2'(sa); w.sb = 2'(sb);
      w.px = px[23:0]; w.py = py[23:0]; w.thr = thr[23:0];
      return w;
   endfunction

   function automatic map_word_type random_word();
      map_word_type w;
      int r;
      longint p;
      r = $urandom_range(99);
      w.op = r < 8 ? OP_SET_ROBOT : r < 32 ? OP_MARK : r < 40 ? OP_RECOLOR :
             r < 56 ? OP_NEAREST : r < 70 ? OP_LOCATE : r < 84 ? OP_ZIGZAG :
             r < 97 ? OP_CENTER : OP_NOP;
      w.cx = 4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(used_cols() - 1));
      w.cy = 4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(used_rows() - 1));
      w.sa = ($urandom_range(9) == 0) ? ST_NONE : 2'($urandom_range(2));
      w.sb = ($urandom_range(9) == 0) ? ST_NONE : 2'($urandom_range(2));
      if ($urandom_range(4) == 0) begin
         w.px = 24'($urandom());
         w.py = 24'($urandom());
      end else begin
         p = org_x + $urandom_range(used_cols() - 1) * edge_mm
             + longint'($urandom_range(32'(2 * edge_mm))) - edge_mm;
         w.px = clamp24(p);
         p = org_y + $urandom_range(used_rows() - 1) * edge_mm
             + longint'($urandom_range(32'(2 * edge_mm))) - edge_mm;
         w.py = clamp24(p);
      end
      w.thr = 24'($urandom_range(4) == 0 ? $urandom() : $urandom_range(32'(2 * edge_mm)));
      return w;
   endfunction

   task automatic test_directed();
      send_word(mk(OP_ZIGZAG, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_SET_ROBOT, 15, 15, 0, 0, 0, 0, 0));
      send_word(mk(OP_ZIGZAG, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_SET_ROBOT, 7, 3, 0, 0, 0, 0, 0));
      send_word(mk(OP_ZIGZAG, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_SET_ROBOT, 6, 7, 0, 0, 0, 0, 0));
      send_word(mk(OP_ZIGZAG, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_MARK, 2, 3, ST_OBSTACLE, 0, 0, 0, 0));
      send_word(mk(OP_MARK, 8, 0, ST_CLEAN, 0, 0, 0, 0));
      send_word(mk(OP_MARK, 1, 1, ST_NONE, 0, 0, 0, 0));
      send_word(mk(OP_NEAREST, 0, 0, ST_OBSTACLE, 0, 1000, 1500, 0));
      send_word(mk(OP_NEAREST, 0, 0, ST_CLEAN, 0, 0, 0, 0));
      send_word(mk(OP_NEAREST, 0, 0, ST_NONE, 0, 0, 0, 0));
      send_word(mk(OP_NEAREST, 0, 0, ST_DIRTY, 0, 8388607, -8388608, 0));
      send_word(mk(OP_LOCATE, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_LOCATE, 0, 0, 0, 0, 1750, 1750, 250));
      send_word(mk(OP_LOCATE, 0, 0, 0, 0, -8388608, 8388607, 16777215));
      send_word(mk(OP_RECOLOR, 0, 0, ST_DIRTY, ST_NONE, 0, 0, 0));
      send_word(mk(OP_RECOLOR, 0, 0, ST_DIRTY, ST_CLEAN, 0, 0, 0));
      send_word(mk(OP_RECOLOR, 0, 0, ST_OBSTACLE, ST_CLEAN, 0, 0, 0));
      send_word(mk(OP_CENTER, 15, 15, 0, 0, 0, 0, 0));
      send_word(mk(OP_NOP, 5, 5, 3, 3, -1, -1, 16777215));
      send_word(mk(OP_MARK, 0, 0, ST_DIRTY, 0, 0, 0, 0));
      wait_idle();
   endtask

   task automatic test_config_extremes();
      set_grid(8388607, -8388608, 65535, 16, 16);
      send_word(mk(OP_CENTER, 15, 15, 0, 0, 0, 0, 0));
      send_word(mk(OP_NEAREST, 0, 0, ST_DIRTY, 0, 8388607, 8388607, 0));
      send_word(mk(OP_LOCATE, 0, 0, 0, 0, -8388608, -8388608, 16777215));
      send_word(mk(OP_MARK, 15, 15, ST_OBSTACLE, 0, 0, 0, 0));
      wait_idle();
      set_grid(-8388608, 8388607, 1, 0, 0);
      send_word(mk(OP_SET_ROBOT, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_ZIGZAG, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_MARK, 1, 0, ST_CLEAN, 0, 0, 0, 0));
      send_word(mk(OP_MARK, 0, 0, ST_CLEAN, 0, 0, 0, 0));
      send_word(mk(OP_CENTER, 15, 0, 0, 0, 0, 0, 0));
      wait_idle();
      set_grid(0, 0, 100, 31, 1);
      send_word(mk(OP_SET_ROBOT, 15, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_ZIGZAG, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_NEAREST, 0, 0, ST_CLEAN, 0, 150, 0, 0));
      wait_idle();
   endtask

   task automatic test_random(int phases, int words_per_phase);
      int c;
      int r;
      for (int ph = 0; ph < phases; ph++) begin
         idling_on = (ph != 2);
         c = $urandom_range(9) == 0 ? $urandom_range(31) : $urandom_range(1, 5);
         r = $urandom_range(9) == 0 ? $urandom_range(31) : $urandom_range(1, 5);
         set_grid($urandom_range(3) == 0 ? longint'($signed(24'($urandom())))
                                         : longint'($urandom_range(4000)) - 2000,
                  $urandom_range(3) == 0 ? longint'($signed(24'($urandom())))
                                         : longint'($urandom_range(4000)) - 2000,
                  $urandom_range(3) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 800),
                  c, r);
         for (int k = 0; k < words_per_phase; k++) send_word(random_word());
         wait_idle();
      end
      idling_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < GRID; i++) begin
         for (int j = 0; j < GRID; j++) grid_state[i][j] = ST_DIRTY;
      end
      robot_col = '0;
      robot_row = '0;
      org_x = 0;
      org_y = 0;
      edge_mm = 500;
      cols_reg = 8;
      rows_reg = 8;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random(19, 100);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("grid_coverage_map verification clean");
      end else begin
         $display("grid_coverage_map verification failed");
      end
      $finish;
   end
endmodule

FILE: filelist.f
hdl/gcm_pkg.sv
hdl/grid_coverage_map.sv
tb/sv/tb_grid_coverage_map.sv
